@@ hw/rtl/rafc_pkg.sv @@
// rafc_pkg: shared types and constants of the rfid ascii frame checker
// holds the classified request type passed from the front end through the queue
// no dependencies
package rafc_pkg;

   // control bytes that restart the frame position
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_ETX = 8'h03;
   localparam logic [7:0] CHAR_STX = 8'h02;

   // hex decode bounds
   localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
   localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
   localparam logic [7:0] CHAR_UPPER_HI = 8'h46;
   localparam logic [7:0] UPPER_BASE    = 8'd10;

   // frame layout in characters
   localparam logic [3:0] UID_CHARS = 4'd10;

   localparam int CARD_ID_W = 40;
   localparam int BYTE_W    = 8;

   // one classified request: restart marker or decoded character value
   typedef struct packed {
      logic             restart;
      logic [BYTE_W-1:0] value;
   } item_type;

endpackage

@@ hw/rtl/rfid_ascii_frame_checker_top.sv @@
// rfid_ascii_frame_checker_top: checks ascii hex frames from an rfid reader
// depends on rafc_pkg, rafc_front, rafc_queue and rafc_back
//
//   channel   direction  payload
//   req_*     in         tdata[7:0]   rx_byte
//   rsp_*     out        tdata[39:0]  card_id, [47:40] received_checksum,
//                        [55:48] computed_checksum, [56] checksum_ok, rest zero
//
// one request per cycle while the queue is not full; a frame result is offered
// the cycle after the back end takes its last character
// synchronous active-high reset clears the queue, frame position and result valid
// a stalled result holds the back end only when the next character would close
// another frame; the two-entry queue keeps the request side open until it fills
module rfid_ascii_frame_checker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // card_id, received_checksum, computed_checksum,
                                    // checksum_ok, zero fill
);
   import rafc_pkg::*;

   item_type    front_item;
   item_type    head_item;
   logic        q_full;
   logic        q_not_empty;
   logic        q_pop;
   logic        push;
   logic [39:0] card_id;
   logic [7:0]  received_checksum;
   logic [7:0]  computed_checksum;
   logic        checksum_ok;

   // front end: classify and decode the incoming byte
   rafc_front u_front (
      .rx_byte (req_tdata),
      .item    (front_item)
   );

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   // queue decouples the request side from the frame logic
   rafc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   // back end: frame assembly and result register
   rafc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (q_not_empty),
      .item              (head_item),
      .item_pop          (q_pop),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .card_id           (card_id),
      .received_checksum (received_checksum),
      .computed_checksum (computed_checksum),
      .checksum_ok       (checksum_ok)
   );

   // pack result fields, card_id in the lowest bits
   assign rsp_tdata = {7'b0000000, checksum_ok, computed_checksum,
                       received_checksum, card_id};

endmodule

@@ hw/rtl/rafc_front.sv @@
// rafc_front: classifies each received byte as a restart marker or a character
// and decodes uppercase hex digits to nibbles; depends on rafc_pkg
module rafc_front (
   input  logic [7:0]         rx_byte,
   output rafc_pkg::item_type item
);
   import rafc_pkg::*;

   logic is_ctrl;
   logic is_digit;
   logic is_upper;

   assign is_ctrl  = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF) ||
                     (rx_byte == CHAR_ETX) || (rx_byte == CHAR_STX);
   assign is_digit = (rx_byte >= CHAR_DIGIT_LO) && (rx_byte <= CHAR_DIGIT_HI);
   assign is_upper = (rx_byte >= CHAR_UPPER_LO) && (rx_byte <= CHAR_UPPER_HI);

   always_comb begin
      item.restart = is_ctrl;
      priority if (is_digit) begin
         item.value = rx_byte - CHAR_DIGIT_LO;
      end else if (is_upper) begin
         item.value = (rx_byte - CHAR_UPPER_LO) + UPPER_BASE;
      end else begin
         // not hex: passed through raw
         item.value = rx_byte;
      end
   end

endmodule

@@ hw/rtl/rafc_queue.sv @@
// rafc_queue: two-entry queue of classified requests between front and back
// depends on rafc_pkg
module rafc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rafc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output rafc_pkg::item_type head_item
);
   import rafc_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/rafc_back.sv @@
// rafc_back: frame state, uid assembly, checksum xor and the result register
// depends on rafc_pkg
module rafc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  rafc_pkg::item_type item,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [39:0]        card_id,
   output logic [7:0]         received_checksum,
   output logic [7:0]         computed_checksum,
   output logic               checksum_ok
);
   import rafc_pkg::*;

   logic [3:0]           pos_ff, pos_in;
   logic [3:0]           nib_ff, nib_in;
   logic [CARD_ID_W-1:0] uid_ff, uid_in;
   logic [BYTE_W-1:0]    xor_ff, xor_in;
   logic                 valid_ff, valid_in;
   logic                 load_result;
   logic                 completes;
   logic [BYTE_W-1:0]    pair_byte;

   logic [CARD_ID_W-1:0] card_ff;
   logic [BYTE_W-1:0]    rcv_ff, cmp_ff;
   logic                 ok_ff;

   // only the character that closes a frame needs the result register free
   assign completes = !item.restart && pos_ff[0] && !(pos_ff < UID_CHARS);
   assign item_pop  = item_valid && (!completes || !valid_ff || rsp_ready);
   assign pair_byte = {nib_ff, 4'b0000} | item.value;

   always_comb begin
      pos_in      = pos_ff;
      nib_in      = nib_ff;
      uid_in      = uid_ff;
      xor_in      = xor_ff;
      load_result = 1'b0;
      valid_in    = valid_ff && !rsp_ready;
      if (item_pop) begin
         priority if (item.restart) begin
            pos_in = '0;
            nib_in = '0;
            uid_in = '0;
            xor_in = '0;
         end else if (!pos_ff[0]) begin
            // high half of a pair
            nib_in = item.value[3:0];
            pos_in = pos_ff + 4'd1;
         end else if (pos_ff < UID_CHARS) begin
            uid_in = {uid_ff[CARD_ID_W-BYTE_W-1:0], pair_byte};
            xor_in = xor_ff ^ pair_byte;
            pos_in = pos_ff + 4'd1;
         end else begin
            // checksum pair completes the frame
            load_result = 1'b1;
            valid_in    = 1'b1;
            pos_in      = '0;
            nib_in      = '0;
            uid_in      = '0;
            xor_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         nib_ff   <= '0;
         uid_ff   <= '0;
         xor_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         nib_ff   <= nib_in;
         uid_ff   <= uid_in;
         xor_ff   <= xor_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         card_ff <= uid_ff;
         rcv_ff  <= pair_byte;
         cmp_ff  <= xor_ff;
         ok_ff   <= (xor_ff == pair_byte);
      end
   end

   assign rsp_valid         = valid_ff;
   assign card_id           = card_ff;
   assign received_checksum = rcv_ff;
   assign computed_checksum = cmp_ff;
   assign checksum_ok       = ok_ff;

endmodule

@@ sim/tb.sv @@
// tb: self-checking testbench for rfid_ascii_frame_checker_top
// predicts each frame result from the accepted request bytes and checks rsp_tdata
// depends on rafc_pkg and the rtl under hw/rtl
module tb;

   import rafc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;   // cycles with no handshake on either side
   localparam int ITEM_TARGET    = 1750;
   localparam int TAIL_CYCLES    = 20;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   // mostly bytes that are not hex: lowercase, G and extremes, with a few hex digits
   localparam logic [95:0] ODD_FRAME = {8'h61, 8'h62, 8'h00, 8'h66, 8'hFF, 8'h47,
                                        8'h7F, 8'h65, 8'h31, 8'h32, 8'h7A, 8'h39};

   typedef struct packed {
      logic             hold;    // pause here until every frame result is back
      logic [BYTE_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [CARD_ID_W-1:0] card_id;
      logic [BYTE_W-1:0]    received_checksum;
      logic [BYTE_W-1:0]    computed_checksum;
      logic                 checksum_ok;
   } frame_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [39:0] card_id, [47:40] received_checksum,
                                   // [55:48] computed_checksum, [56] checksum_ok

   req_item_type     pending_reqs[$];
   frame_result_type expected_frames[$];
   int               item_total  = 0;
   int               error_count = 0;

   // predictor state, mirrors the frame decoder
   logic [3:0]           frame_pos;
   logic [3:0]           high_nib;
   logic [CARD_ID_W-1:0] uid_acc;
   logic [BYTE_W-1:0]    xor_acc;

   // driver and monitor pacing
   int           send_wait, send_run, take_wait, take_run;
   int           quiet_cycles = 0;
   logic         holding;
   req_item_type next_req;

   rfid_ascii_frame_checker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // frame decode predictor
   // ------------------------------------------------------------------

   function automatic logic is_control(input logic [7:0] c);
      return (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_ETX) || (c == CHAR_STX);
   endfunction

   // uppercase hex to a nibble, anything else passes through untouched
   function automatic logic [7:0] hex_value(input logic [7:0] c);
      if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
         return c - CHAR_DIGIT_LO;
      end
      if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
         return UPPER_BASE + (c - CHAR_UPPER_LO);
      end
      return c;
   endfunction

   task automatic clear_frame();
      frame_pos = '0;
      high_nib  = '0;
      uid_acc   = '0;
      xor_acc   = '0;
   endtask

   task automatic decode_rx_byte(input logic [7:0] c);
      logic [7:0]       v;
      logic [7:0]       pair;
      frame_result_type res;
      if (is_control(c)) begin
         clear_frame();
      end else begin
         v = hex_value(c);
         if (!frame_pos[0]) begin
            // high half of a pair: only the low nibble survives
            high_nib  = v[3:0];
            frame_pos = frame_pos + 4'd1;
         end else begin
            // low half: full byte ored in, so raw characters can clobber the high nibble
            pair = {high_nib, 4'b0000} | v;
            if (frame_pos < UID_CHARS) begin
               uid_acc   = {uid_acc[CARD_ID_W-9:0], pair};
               xor_acc   = xor_acc ^ pair;
               frame_pos = frame_pos + 4'd1;
            end else begin
               res.card_id           = uid_acc;
               res.received_checksum = pair;
               res.computed_checksum = xor_acc;
               res.checksum_ok       = (xor_acc == pair);
               expected_frames.push_back(res);
               clear_frame();
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   task automatic push_byte(input logic [7:0] b);
      req_item_type it;
      it.hold  = 1'b0;
      it.value = b;
      pending_reqs.push_back(it);
      item_total++;
   endtask

   task automatic push_hold();
      req_item_type it;
      it.hold  = 1'b1;
      it.value = '0;
      pending_reqs.push_back(it);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? CHAR_DIGIT_LO + n : CHAR_UPPER_LO + (n - 4'd10);
   endfunction

   function automatic logic [7:0] pick_control();
      case ($urandom_range(0, 3))
         0: return CHAR_CR;
         1: return CHAR_LF;
         2: return CHAR_ETX;
         default: return CHAR_STX;
      endcase
   endfunction

   // lowercase hex half the time, otherwise any byte that does not restart the frame
   function automatic logic [7:0] pick_raw_char();
      logic [7:0] c;
      if ($urandom_range(0, 1) == 0) begin
         return CHAR_LOWER_A + 8'($urandom_range(0, 5));
      end
      do begin
         c = 8'($urandom_range(0, 255));
      end while (is_control(c));
      return c;
   endfunction

   function automatic logic [7:0] uid_xor(input logic [CARD_ID_W-1:0] uid);
      return uid[39:32] ^ uid[31:24] ^ uid[23:16] ^ uid[15:8] ^ uid[7:0];
   endfunction

   // twelve characters; each is swapped for a raw byte from pick_raw_char with a chance of raw_pct percent
   task automatic push_frame(input logic [CARD_ID_W-1:0] uid, input logic [7:0] chk,
                             input int raw_pct);
      logic [47:0] word;
      word = {uid, chk};
      for (int i = 0; i < 12; i++) begin
         if ($urandom_range(0, 99) < raw_pct) begin
            push_byte(pick_raw_char());
         end else begin
            push_byte(hex_char(word[47-4*i -: 4]));
         end
      end
   endtask

   // burst runs with no idling, otherwise a random idle gap drawn per item
   task automatic pick_idle(inout int run_left, output int cycles);
      if (run_left > 0) begin
         run_left--;
         cycles = 0;
      end else if ($urandom_range(0, 39) == 0) begin
         run_left = $urandom_range(10, 60);
         cycles   = 0;
      end else begin
         cycles = $urandom_range(0, 15);
      end
   endtask

   // ------------------------------------------------------------------
   // request driver: one request per handshake, idle gap drawn per item
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_wait  = 0;
         send_run   = 0;
         clear_frame();
      end else begin
         holding = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            decode_rx_byte(req_tdata);
         end
         if (!holding) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_reqs[0].hold) begin
               // sender pause: nothing goes out until all frame results are back
               req_tvalid <= 1'b0;
               if (expected_frames.size() == 0) begin
                  next_req = pending_reqs.pop_front();
               end
            end else begin
               next_req = pending_reqs.pop_front();
               req_tdata  <= next_req.value;
               req_tvalid <= 1'b1;
               pick_idle(send_run, send_wait);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor: stall counted only while a result is offered
   // ------------------------------------------------------------------
   task automatic check_frame_result(input logic [63:0] data);
      frame_result_type want;
      if (expected_frames.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, data);
         error_count++;
      end else begin
         want = expected_frames.pop_front();
         if (data[39:0] !== want.card_id) begin
            $display("%0t: card_id expected %h actual %h", $time, want.card_id, data[39:0]);
            error_count++;
         end
         if (data[47:40] !== want.received_checksum) begin
            $display("%0t: received_checksum expected %h actual %h", $time,
                     want.received_checksum, data[47:40]);
            error_count++;
         end
         if (data[55:48] !== want.computed_checksum) begin
            $display("%0t: computed_checksum expected %h actual %h", $time,
                     want.computed_checksum, data[55:48]);
            error_count++;
         end
         if (data[56] !== want.checksum_ok) begin
            $display("%0t: checksum_ok expected %b actual %b", $time,
                     want.checksum_ok, data[56]);
            error_count++;
         end
         if (data[63:57] !== 7'd0) begin
            $display("%0t: zero fill expected %h actual %h", $time, 7'd0, data[63:57]);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         take_wait  = 0;
         take_run   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_frame_result(rsp_tdata);
            pick_idle(take_run, take_wait);
         end else if (rsp_tvalid && take_wait > 0) begin
            take_wait--;
         end
         rsp_tready <= (take_wait == 0);
      end
   end

   // watchdog: any handshake on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      logic [CARD_ID_W-1:0] uid;
      logic [7:0]           chk;
      int                   pick;
      int                   n;

      // directed: clean frame with good checksum covering 0, 9, A and F
      push_byte(CHAR_STX);
      uid = 40'hF09A5FA009;
      push_frame(uid, uid_xor(uid), 0);
      // restarts mid-frame, then a frame of mostly non-hex bytes and extremes
      push_byte(CHAR_LOWER_A + 8'd2);
      push_byte(CHAR_LF);
      push_byte(CHAR_DIGIT_LO + 8'd5);
      push_byte(CHAR_ETX);
      for (int i = 0; i < 12; i++) begin
         push_byte(ODD_FRAME[95-8*i -: 8]);
      end
      push_byte(CHAR_CR);
      push_hold();

      // random: mostly well-formed frames, some broken ones and raw noise
      while (item_total < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 1) == 0) begin
               push_byte(CHAR_STX);
            end
            uid = 40'({$urandom, $urandom});
            chk = ($urandom_range(0, 9) < 6) ? uid_xor(uid) : 8'($urandom_range(0, 255));
            push_frame(uid, chk, ($urandom_range(0, 3) == 0) ? 8 : 0);
            case ($urandom_range(0, 3))
               0: ;
               1: push_byte(CHAR_CR);
               2: begin
                  push_byte(CHAR_CR);
                  push_byte(CHAR_LF);
               end
               default: push_byte(CHAR_ETX);
            endcase
         end else if (pick < 85) begin
            // frame cut short by a control byte
            push_byte(CHAR_STX);
            n = $urandom_range(1, 11);
            for (int i = 0; i < n; i++) begin
               push_byte(hex_char(4'($urandom_range(0, 15))));
            end
            push_byte(pick_control());
         end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               push_byte(8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 49) == 0) begin
            push_hold();
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_frames.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
